// ===== hw/rtl/uid_allow_list_table_defines.svh =====
// assertion macros for the allow list table
`ifndef UID_ALLOW_LIST_TABLE_DEFINES_SVH
`define UID_ALLOW_LIST_TABLE_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define UIDAL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("uidal check failed");

// next-cycle implication, checked while out of reset
`define UIDAL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("uidal check failed");

`endif

// ===== hw/rtl/uidal_pkg.sv =====
package uidal_pkg;

  localparam int TABLE_DEPTH_DEF = 512;
  localparam int KEY_WIDTH_DEF   = 64;

  localparam int CARD_KEY_W  = 64;
  localparam int STATUS_W    = 3;
  localparam int MODE_W      = 2;
  localparam int COUNT_OUT_W = 10;

  localparam logic [STATUS_W-1:0] ST_GRANTED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DENIED    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd5;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd6;

  localparam logic [MODE_W-1:0] MODE_CHECK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

  localparam logic KIND_CARD   = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  // broadcast controls for the row of cells
  typedef struct packed {
    logic step;    // rotate the ring by one slot
    logic keep;    // head entry goes back in at the ring tail
    logic append;  // write the new key at the append slot
  } ring_ctrl_t;

endpackage

// ===== hw/rtl/uidal_cell.sv =====
module uidal_cell #(
  parameter int TABLE_DEPTH = uidal_pkg::TABLE_DEPTH_DEF,
  parameter int KEY_WIDTH   = uidal_pkg::KEY_WIDTH_DEF,
  parameter int IDX         = 0
) (
  input  logic                               clk,
  input  uidal_pkg::ring_ctrl_t              ctrl,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0]   ring_len,
  input  logic [$clog2(TABLE_DEPTH)-1:0]     wr_idx,
  input  logic [KEY_WIDTH-1:0]               right_key,
  input  logic [KEY_WIDTH-1:0]               head_key,
  input  logic [KEY_WIDTH-1:0]               new_key,
  output logic [KEY_WIDTH-1:0]               key
);

  localparam int CW = $clog2(TABLE_DEPTH+1);
  localparam int IW = $clog2(TABLE_DEPTH);
  localparam logic [CW-1:0] POS  = CW'(IDX + 1);
  localparam logic [IW-1:0] SLOT = IW'(IDX);

  // inside the ring: take the neighbor; at the tail: take the head back unless it is dropped; on append: the new key
  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      if (POS < ring_len) begin
        key <= right_key;
      end else if (POS == ring_len && ctrl.keep) begin
        key <= head_key;
      end
    end else if (ctrl.append && wr_idx == SLOT) begin
      key <= new_key;
    end
  end

endmodule

// ===== hw/rtl/uidal_chain.sv =====
module uidal_chain #(
  parameter int TABLE_DEPTH = uidal_pkg::TABLE_DEPTH_DEF,
  parameter int KEY_WIDTH   = uidal_pkg::KEY_WIDTH_DEF
) (
  input  logic                               clk,
  input  uidal_pkg::ring_ctrl_t              ctrl,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0]   ring_len,
  input  logic [$clog2(TABLE_DEPTH)-1:0]     wr_idx,
  input  logic [KEY_WIDTH-1:0]               new_key,
  output logic [KEY_WIDTH-1:0]               head_key
);

  logic [KEY_WIDTH-1:0] keys [TABLE_DEPTH];

  assign head_key = keys[0];

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic [KEY_WIDTH-1:0] right;

    // last cell never shifts in from the right
    if (i < TABLE_DEPTH - 1) begin : g_mid
      assign right = keys[i+1];
    end else begin : g_end
      assign right = keys[i];
    end

    uidal_cell #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .KEY_WIDTH  (KEY_WIDTH),
      .IDX        (i)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .ring_len (ring_len),
      .wr_idx   (wr_idx),
      .right_key(right),
      .head_key (keys[0]),
      .new_key  (new_key),
      .key      (keys[i])
    );
  end

endmodule

// ===== hw/rtl/uid_allow_list_table.sv =====
// channel | signals                         | direction | payload
// in      | in_valid / in_ready             | request   | kind, card_key
// out     | out_valid / out_ready           | result    | status, authorized, entry_count
// cfg     | cfg_valid / cfg_ready           | write     | mode
//
// each request rotates the whole key ring once, one scan step per slot, then takes a
// finish step; a new request is taken only after the finish step, back in idle
// the single ring of cells, one slot per cycle, is what the scan walks through
// reset empties the table at once (count to zero), no clearing pass
// the finished result sits in an output register; a stall there holds only the
// finish step, the next request is taken as soon as the result is registered
module uid_allow_list_table #(
  parameter int TABLE_DEPTH = uidal_pkg::TABLE_DEPTH_DEF,
  parameter int KEY_WIDTH   = uidal_pkg::KEY_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // request channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 kind,
  input  logic [uidal_pkg::CARD_KEY_W-1:0]     card_key,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [uidal_pkg::STATUS_W-1:0]       status,
  output logic                                 authorized,
  output logic [uidal_pkg::COUNT_OUT_W-1:0]    entry_count,
  // mode register write
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [uidal_pkg::MODE_W-1:0]         mode
);

  localparam int CW = $clog2(TABLE_DEPTH+1);
  localparam int IW = $clog2(TABLE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam logic [IW-1:0] LAST_T  = IW'(TABLE_DEPTH - 1);
  localparam int MODE_W_L = uidal_pkg::MODE_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t                state;
  logic [MODE_W_L-1:0]   cur_mode;
  logic                  op_remove;
  logic                  op_add;
  logic                  op_check;
  logic [KEY_WIDTH-1:0]  key_q;
  logic [CW-1:0]         count;
  logic [CW-1:0]         drops;
  logic [IW-1:0]         t;
  logic                  hit;

  uidal_pkg::ring_ctrl_t ctrl;
  logic [KEY_WIDTH-1:0]  head_key;
  logic [CW-1:0]         ring_len;
  logic                  head_valid;
  logic                  match;
  logic                  drop;
  logic                  full;
  logic                  do_append;
  logic                  done_go;
  logic [CW-1:0]         count_next;
  logic [uidal_pkg::STATUS_W-1:0] status_next;

  // mode register, written only while idle
  assign cfg_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_mode <= uidal_pkg::MODE_CHECK;
    end else if (cfg_valid && cfg_ready) begin
      cur_mode <= mode;
    end
  end

  assign in_ready = (state == S_IDLE);

  // scan datapath: the head cell is the entry under test this cycle
  assign ring_len   = DEPTH_C - drops;
  assign head_valid = CW'(t) < count;
  assign match      = head_valid && (head_key == key_q);
  assign drop       = match && op_remove;

  // finish step: result goes out once the output register is free
  assign done_go    = (state == S_DONE) && (!out_valid || out_ready);
  assign full       = (count == DEPTH_C);
  assign do_append  = op_add && !hit && !full;

  assign ctrl.step   = (state == S_SCAN);
  assign ctrl.keep   = !drop;
  assign ctrl.append = done_go && do_append;

  always_comb begin
    count_next = count - drops;
    if (do_append) begin
      count_next = count + CW'(1);
    end
  end

  always_comb begin
    if (op_remove) begin
      status_next = hit ? uidal_pkg::ST_REMOVED : uidal_pkg::ST_NOT_FOUND;
    end else if (op_add) begin
      if (hit) begin
        status_next = uidal_pkg::ST_PRESENT;
      end else if (full) begin
        status_next = uidal_pkg::ST_FULL;
      end else begin
        status_next = uidal_pkg::ST_ADDED;
      end
    end else begin
      status_next = hit ? uidal_pkg::ST_GRANTED : uidal_pkg::ST_DENIED;
    end
  end

  uidal_chain #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .KEY_WIDTH  (KEY_WIDTH)
  ) u_chain (
    .clk     (clk),
    .ctrl    (ctrl),
    .ring_len(ring_len),
    .wr_idx  (count[IW-1:0]),
    .new_key (key_q),
    .head_key(head_key)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (t == LAST_T) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (done_go) begin
            state <= S_IDLE;
            count <= count_next;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // request latch and scan bookkeeping
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      key_q     <= card_key[KEY_WIDTH-1:0];
      op_remove <= (kind == uidal_pkg::KIND_REMOVE) || (cur_mode == uidal_pkg::MODE_REMOVE);
      op_add    <= (kind == uidal_pkg::KIND_CARD) && (cur_mode == uidal_pkg::MODE_ADD);
      op_check  <= (kind == uidal_pkg::KIND_CARD) && (cur_mode != uidal_pkg::MODE_ADD)
                   && (cur_mode != uidal_pkg::MODE_REMOVE);
      t         <= '0;
      drops     <= '0;
      hit       <= 1'b0;
    end else if (state == S_SCAN) begin
      t <= t + IW'(1);
      if (match) begin
        hit <= 1'b1;
      end
      if (drop) begin
        drops <= drops + CW'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_go) begin
      status      <= status_next;
      authorized  <= op_check && hit;
      entry_count <= uidal_pkg::COUNT_OUT_W'(count_next);
    end
  end

endmodule

// ===== hw/rtl/uidal_checker.sv =====
`include "uid_allow_list_table_defines.svh"

module uidal_checker #(
  parameter int TABLE_DEPTH = uidal_pkg::TABLE_DEPTH_DEF
) (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic [uidal_pkg::STATUS_W-1:0]       status,
  input logic                                 authorized,
  input logic [uidal_pkg::COUNT_OUT_W-1:0]    entry_count
);

  localparam int DEPTH_CHK = TABLE_DEPTH;

  // a grant is the only result that authorizes
  `UIDAL_ASSERT_NOW(a_auth_grant, out_valid && authorized, status == uidal_pkg::ST_GRANTED)

  // an add leaves at least one entry
  `UIDAL_ASSERT_NOW(a_add_count, out_valid && status == uidal_pkg::ST_ADDED && DEPTH_CHK < 1024, entry_count != '0)

  // the block is busy right after taking a request
  `UIDAL_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready)

  // a stalled result holds
  `UIDAL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(entry_count))

endmodule

bind uid_allow_list_table uidal_checker #(
  .TABLE_DEPTH(TABLE_DEPTH)
) u_uidal_checker (.*);
